// File: design/peg_pkg.sv
// Shared types and constants for the pulse envelope generator.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package peg_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned PpbW    = 5;
  localparam int unsigned PulseW  = 4;
  localparam int unsigned SegW    = 2;
  localparam int unsigned CfgIdxW = 3;

  // Ratio quotient reaches 2^16, so it needs one bit more than the data.
  localparam int unsigned QuotW    = 17;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned DivCntW  = 5;

  // Shared multiplier: wide operand holds the square of the quotient.
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 17;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned AccW  = 34;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_LENGTH    = 3'd0,
    CFG_PULSES_PER_BEAT = 3'd1,
    CFG_RISE_TICKS      = 3'd2,
    CFG_FALL_TICKS      = 3'd3,
    CFG_BASE_LEVEL      = 3'd4,
    CFG_ACCENT_GAIN     = 3'd5,
    CFG_NORMAL_GAIN     = 3'd6
  } cfg_idx_e;

  typedef enum logic [SegW-1:0] {
    SEG_RISE = 2'd0,
    SEG_FALL = 2'd1,
    SEG_GAP  = 2'd2
  } seg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV,
    ST_SQUARE,
    ST_CUBE,
    ST_MIX_BASE,
    ST_MIX_PEAK,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_PEAK,
    MUL_SQUARE,
    MUL_CUBE,
    MUL_MIX_BASE,
    MUL_MIX_PEAK
  } mul_sel_e;

  typedef struct packed {
    logic     accept;    // advance counters with the incoming tick
    logic     setup;     // classify segment, load divider
    logic     div_step;  // one restoring division step
    mul_sel_e mul_sel;   // multiplier operands and destination
    logic     out_load;  // capture result into the output register
  } cmd_t;

  typedef struct packed {
    logic gap;       // current tick lies in the gap
    logic div_last;  // divider performs its final step
  } status_t;

endpackage

`default_nettype wire

// File: design/peg_div.sv
// Restoring divider producing floor((num << 16) / den) for num <= den.
// One quotient bit per cycle while step_i is high; depends on peg_pkg.
`default_nettype none

module peg_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire                              step_i,
  input  wire  [peg_pkg::DataW-1:0]        num_i,
  input  wire  [peg_pkg::DataW-1:0]        den_i,
  output logic [peg_pkg::QuotW-1:0]        quot_o,
  output logic                             last_o
);
  import peg_pkg::*;

  logic [DataW:0]       rem_q, rem_d;
  logic [DataW-1:0]     den_q;
  logic [QuotW-1:0]     quot_q, quot_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 ge;
  logic [DataW:0]       diff;
  logic [DataW:0]       part;

  always_comb begin
    ge     = rem_q >= {1'b0, den_q};
    diff   = rem_q - {1'b0, den_q};
    part   = ge ? diff : rem_q;
    rem_d  = {part[DataW-1:0], 1'b0};
    quot_d = {quot_q[QuotW-2:0], ge};
    cnt_d  = cnt_q + DivCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (step_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;
  assign last_o = cnt_q == DivCntW'(DivSteps - 1);

endmodule

`default_nettype wire

// File: design/peg_datapath.sv
// Datapath: configuration registers, tick and pulse counters, shared
// multiplier, divider instance and output payload. Depends on peg_pkg, peg_div.
`default_nettype none

module peg_datapath #(
  parameter int unsigned LEVEL_FRAC_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [peg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [peg_pkg::DataW-1:0]        cfg_data_i,
  input  wire                              restart_i,
  input  peg_pkg::cmd_t                    cmd_i,
  output peg_pkg::status_t                 status_o,
  output logic [peg_pkg::DataW-1:0]        level_o,
  output logic [peg_pkg::PulseW-1:0]       pulse_index_o,
  output logic [peg_pkg::SegW-1:0]         segment_o
);
  import peg_pkg::*;

  localparam logic [32:0] RoundK = 33'd1 << (LEVEL_FRAC_BITS - 1);

  // configuration
  logic [DataW-1:0] plen_q, rise_q, fall_q, base_q, accent_q, normal_q;
  logic [PpbW-1:0]  ppb_q;

  // counters
  logic [DataW-1:0]  tick_q, tick_d;
  logic [PulseW-1:0] pc_q, pc_d;

  // working registers
  seg_e              seg_q;
  logic [DataW-1:0]  peak_q;
  logic [MulAW-1:0]  sq_q;
  logic [QuotW-1:0]  cube_q;
  logic [AccW-1:0]   acc_q;

  logic [DataW-1:0]  level_q;
  logic [PulseW-1:0] pidx_q;
  seg_e              seg_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= 16'd15;
      ppb_q    <= 5'd4;
      rise_q   <= 16'd3;
      fall_q   <= 16'd6;
      base_q   <= 16'd4096;
      accent_q <= 16'd6144;
      normal_q <= 16'd5120;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PULSE_LENGTH:    plen_q   <= cfg_data_i;
        CFG_PULSES_PER_BEAT: ppb_q    <= cfg_data_i[PpbW-1:0];
        CFG_RISE_TICKS:      rise_q   <= cfg_data_i;
        CFG_FALL_TICKS:      fall_q   <= cfg_data_i;
        CFG_BASE_LEVEL:      base_q   <= cfg_data_i;
        CFG_ACCENT_GAIN:     accent_q <= cfg_data_i;
        CFG_NORMAL_GAIN:     normal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counter advance: a zero length acts as one, pulses per beat clamp to 1..16.
  logic [DataW-1:0]  len_eff, tick_base;
  logic [PpbW-1:0]   ppb_eff, pc_inc;
  logic [PulseW-1:0] pc_base;
  logic [DataW:0]    tick_inc;

  always_comb begin
    len_eff   = (plen_q == '0) ? DataW'(1) : plen_q;
    if (ppb_q == '0) begin
      ppb_eff = PpbW'(1);
    end else if (ppb_q > PpbW'(16)) begin
      ppb_eff = PpbW'(16);
    end else begin
      ppb_eff = ppb_q;
    end
    tick_base = restart_i ? '0 : tick_q;
    pc_base   = restart_i ? '0 : pc_q;
    tick_inc  = {1'b0, tick_base} + (DataW+1)'(1);
    pc_inc    = {1'b0, pc_base} + PpbW'(1);
    if (tick_inc >= {1'b0, len_eff}) begin
      tick_d = '0;
      pc_d   = (pc_inc >= ppb_eff) ? '0 : pc_inc[PulseW-1:0];
    end else begin
      tick_d = tick_inc[DataW-1:0];
      pc_d   = pc_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      pc_q   <= '0;
    end else if (cmd_i.accept) begin
      tick_q <= tick_d;
      pc_q   <= pc_d;
    end
  end

  // Segment classification and divider operands.
  logic           rise_hit, fall_hit;
  logic [DataW:0] win_end;
  seg_e           seg_cls;
  logic [DataW-1:0] div_num, div_den;

  always_comb begin
    rise_hit = tick_q < rise_q;
    win_end  = {1'b0, rise_q} + {1'b0, fall_q};
    fall_hit = {1'b0, tick_q} < win_end;
    if (rise_hit) begin
      seg_cls = SEG_RISE;
    end else if (fall_hit) begin
      seg_cls = SEG_FALL;
    end else begin
      seg_cls = SEG_GAP;
    end
    div_num = rise_hit ? (rise_q - tick_q) : (tick_q - rise_q);
    div_den = rise_hit ? rise_q : fall_q;
  end

  logic [QuotW-1:0] quot;
  logic             div_last;

  peg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.setup),
    .step_i  (cmd_i.div_step),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .last_o  (div_last)
  );

  assign status_o.gap      = seg_cls == SEG_GAP;
  assign status_o.div_last = div_last;

  // Shared multiplier. Both segments reduce to base*c + peak*(1 - c).
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [DataW-1:0] gain;
  logic [32:0]      pk_sum, pk_shift;
  logic [DataW-1:0] peak_d;

  always_comb begin
    gain = (pc_q == '0) ? accent_q : normal_q;
    case (cmd_i.mul_sel)
      MUL_PEAK: begin
        mul_a = MulAW'(base_q);
        mul_b = MulBW'(gain);
      end
      MUL_SQUARE: begin
        mul_a = MulAW'(quot);
        mul_b = quot;
      end
      MUL_CUBE: begin
        mul_a = sq_q;
        mul_b = quot;
      end
      MUL_MIX_BASE: begin
        mul_a = MulAW'(base_q);
        mul_b = cube_q;
      end
      MUL_MIX_PEAK: begin
        mul_a = MulAW'(peak_q);
        mul_b = 17'h10000 - cube_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = mul_a * mul_b;
    pk_sum   = {1'b0, prod[31:0]} + RoundK;
    pk_shift = pk_sum >> LEVEL_FRAC_BITS;
    peak_d   = (|pk_shift[32:DataW]) ? '1 : pk_shift[DataW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      seg_q <= seg_cls;
    end
    case (cmd_i.mul_sel)
      MUL_PEAK:     peak_q <= peak_d;
      MUL_SQUARE:   sq_q   <= prod[MulAW-1:0];
      MUL_CUBE:     cube_q <= prod[48:32];
      MUL_MIX_BASE: acc_q  <= AccW'(prod[32:0]) + AccW'(32768);
      MUL_MIX_PEAK: acc_q  <= acc_q + prod[AccW-1:0];
      default: ;
    endcase
    if (cmd_i.out_load) begin
      if (seg_q == SEG_GAP) begin
        level_q <= base_q;
      end else begin
        level_q <= (|acc_q[AccW-1:32]) ? '1 : acc_q[31:16];
      end
      pidx_q    <= pc_q;
      seg_out_q <= seg_q;
    end
  end

  assign level_o       = level_q;
  assign pulse_index_o = pidx_q;
  assign segment_o     = seg_out_q;

  // A restart tick lands on the first or second tick of pulse zero or one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && restart_i) |=> (tick_q <= DataW'(1)))
    else $error("tick counter out of range after restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && restart_i) |=> (pc_q <= PulseW'(1)))
    else $error("pulse counter out of range after restart");

endmodule

`default_nettype wire

// File: design/peg_ctrl.sv
// Controller state machine: sequences setup, division, multiplies and the
// output handshake. Depends on peg_pkg.
`default_nettype none

module peg_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  peg_pkg::status_t  status_i,
  output peg_pkg::cmd_t     cmd_o
);
  import peg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_PEAK;
      ST_PEAK:     state_d = status_i.gap ? ST_DONE : ST_DIV;
      ST_DIV:      if (status_i.div_last) state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_CUBE;
      ST_CUBE:     state_d = ST_MIX_BASE;
      ST_MIX_BASE: state_d = ST_MIX_PEAK;
      ST_MIX_PEAK: state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_PEAK: begin
        cmd_o.setup   = 1'b1;
        cmd_o.mul_sel = MUL_PEAK;
      end
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_SQUARE:   cmd_o.mul_sel  = MUL_SQUARE;
      ST_CUBE:     cmd_o.mul_sel  = MUL_CUBE;
      ST_MIX_BASE: cmd_o.mul_sel  = MUL_MIX_BASE;
      ST_MIX_PEAK: cmd_o.mul_sel  = MUL_MIX_PEAK;
      ST_DONE:     cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/pulse_envelope_generator_top.sv
// Top level of the pulse envelope generator: controller plus datapath.
// Depends on peg_pkg, peg_ctrl, peg_datapath (which holds peg_div).
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  ---------------------------
//   in        input      in_valid_i / in_ready_o   restart_i
//   out       output     out_valid_o / out_ready_i level_o, pulse_index_o,
//                                                   segment_o
//   cfg       input      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// A tick in the rise or fall window runs from transfer to result through the
// peak multiply, the 17-step restoring divider, then four passes through
// the one shared multiplier. A tick in the gap skips the divider and the
// later multiplies. After each result the block returns to idle before it
// takes the next tick. One tick is in flight at a time; in_ready_o is
// high only while idle.
// A result held in the output register does not stall the next tick until
// that tick's own result is ready to be loaded.
// Reset clears counters and loads the default configuration; no sweep.
`default_nettype none

module pulse_envelope_generator_top #(
  parameter int unsigned LEVEL_FRAC_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire  [peg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [peg_pkg::DataW-1:0]        cfg_data_i,
  // tick input
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              restart_i,
  // level output
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [peg_pkg::DataW-1:0]        level_o,
  output logic [peg_pkg::PulseW-1:0]       pulse_index_o,
  output logic [peg_pkg::SegW-1:0]         segment_o
);
  import peg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each tick: advance counters, compute peak, divide, cube, mix.
  peg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold configuration, counters, arithmetic and the output payload.
  peg_datapath #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .level_o       (level_o),
    .pulse_index_o (pulse_index_o),
    .segment_o     (segment_o)
  );

  // One tick at a time: a transfer drops ready for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a tick is still in progress");

  // A delivered segment is always rise, fall or gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (segment_o == SEG_RISE || segment_o == SEG_FALL ||
                     segment_o == SEG_GAP))
    else $error("invalid segment code on output");

endmodule

`default_nettype wire

// File: tb/sv/pulse_envelope_generator_top_tb.sv
// Self-checking testbench for pulse_envelope_generator_top: ticks go in, levels come out.
// Each result is checked against a cycle-free predictor of the cubic attack/decay envelope.
// Depends on peg_pkg and the pulse_envelope_generator_top RTL.
`default_nettype none

module pulse_envelope_generator_top_tb;
  import peg_pkg::*;

  localparam int unsigned LevelFracBits    = 12;
  // Index 7 has no register behind it; the block must ignore the write.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned MaxReports       = 10;
  // Margin for the block to finish the longest tick before touching config.
  localparam int unsigned SettleCycles     = 32;
  // Long receiver stall used to back the block up.
  localparam int unsigned OutputHoldCycles = 400;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned StallLimit       = 3000;

  typedef struct packed {
    logic [DataW-1:0]  level;
    logic [PulseW-1:0] pulse;
    seg_e              seg;
  } envelope_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [DataW-1:0]    cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                restart_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [DataW-1:0]    level_o;
  logic [PulseW-1:0]   pulse_index_o;
  logic [SegW-1:0]     segment_o;

  // Predictor copy of the register file and the two counters.
  logic [DataW-1:0]    cfg_pulse_len;
  logic [PpbW-1:0]     cfg_ppb;
  logic [DataW-1:0]    cfg_rise;
  logic [DataW-1:0]    cfg_fall;
  logic [DataW-1:0]    cfg_base;
  logic [DataW-1:0]    cfg_accent;
  logic [DataW-1:0]    cfg_normal;
  logic [DataW-1:0]    tick_pos;
  logic [PulseW-1:0]   pulse_pos;

  envelope_t           pending_envelopes[$];
  int unsigned         fail_count   = 0;
  int unsigned         stall_cycles = 0;
  bit                  tx_gaps_on   = 1'b1;
  bit                  rx_gaps_on   = 1'b1;
  bit                  hold_request = 1'b0;

  always #4 clk_i = ~clk_i;

  pulse_envelope_generator_top #(
    .LEVEL_FRAC_BITS(LevelFracBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_o      (level_o),
    .pulse_index_o(pulse_index_o),
    .segment_o    (segment_o)
  );

  // ---------------------------------------------------------------------------
  // Envelope predictor
  // ---------------------------------------------------------------------------

  task automatic reset_envelope_state();
    cfg_pulse_len = 16'd15;
    cfg_ppb       = 5'd4;
    cfg_rise      = 16'd3;
    cfg_fall      = 16'd6;
    cfg_base      = 16'd4096;
    cfg_accent    = 16'd6144;
    cfg_normal    = 16'd5120;
    tick_pos      = '0;
    pulse_pos     = '0;
  endtask

  // Q16 crossfade from one level to another, rounded and saturated.
  function automatic logic [DataW-1:0] blend_levels(input longint unsigned from_lvl,
                                                     input longint unsigned to_lvl,
                                                     input longint unsigned w);
    longint unsigned acc;
    acc = (from_lvl * (64'd65536 - w) + to_lvl * w + 64'd32768) >> 16;
    return (acc > 64'd65535) ? 16'hFFFF : 16'(acc);
  endfunction

  // Advance the counters by one tick and return the level it produces.
  function automatic envelope_t advance_envelope(input logic restart);
    longint unsigned len, ppb, rise, fall, loc, gain, peak, base, r, d, w, u;
    envelope_t       res;
    len  = (cfg_pulse_len == 0) ? 1 : cfg_pulse_len;
    ppb  = (cfg_ppb == 0) ? 1 : cfg_ppb;
    if (ppb > 16) ppb = 16;
    if (restart) begin
      tick_pos  = '0;
      pulse_pos = '0;
    end
    // Compare at full width so counters left past a shrunk limit still wrap.
    if (64'(tick_pos) + 64'd1 >= len) begin
      tick_pos  = '0;
      pulse_pos = (64'(pulse_pos) + 64'd1 >= ppb) ? 4'd0 : pulse_pos + 4'd1;
    end else begin
      tick_pos = tick_pos + 16'd1;
    end
    loc  = tick_pos;
    rise = cfg_rise;
    fall = cfg_fall;
    base = cfg_base;
    gain = (pulse_pos == 0) ? cfg_accent : cfg_normal;
    peak = (base * gain + (64'd1 << (LevelFracBits - 1))) >> LevelFracBits;
    if (peak > 64'd65535) peak = 64'd65535;
    res.pulse = pulse_pos;
    if (loc < rise) begin
      // Ease-out: weight approaches one quickly, then flattens.
      r         = rise - loc;
      d         = (r << 16) / rise;
      w         = 64'd65536 - ((d * d * d) >> 32);
      res.level = blend_levels(base, peak, w);
      res.seg   = SEG_RISE;
    end else if (loc < rise + fall) begin
      // Ease-in: weight starts slow, then accelerates back to base.
      u         = ((loc - rise) << 16) / fall;
      w         = (u * u * u) >> 32;
      res.level = blend_levels(peak, base, w);
      res.seg   = SEG_FALL;
    end else begin
      res.level = cfg_base;
      res.seg   = SEG_GAP;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  // Offer one tick, hold it until the transfer, then maybe idle the input.
  // Valid stays high when no gap follows so back-to-back ticks never toggle it.
  task automatic send_tick(input logic restart);
    int unsigned gap;
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    pending_envelopes.push_back(advance_envelope(restart));
    gap = pick_gap(tx_gaps_on);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_ticks(input int unsigned count, input int unsigned restart_pct);
    repeat (count) send_tick($urandom_range(0, 99) < restart_pct);
  endtask

  // Drop the input, wait for every outstanding level, then let the block go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_envelopes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the enable drops on the following edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_PULSE_LENGTH:    cfg_pulse_len = value;
      CFG_PULSES_PER_BEAT: cfg_ppb       = value[PpbW-1:0];
      CFG_RISE_TICKS:      cfg_rise      = value;
      CFG_FALL_TICKS:      cfg_fall      = value;
      CFG_BASE_LEVEL:      cfg_base      = value;
      CFG_ACCENT_GAIN:     cfg_accent    = value;
      CFG_NORMAL_GAIN:     cfg_normal    = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, long hold on request
  // ---------------------------------------------------------------------------

  initial begin : output_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = OutputHoldCycles;
      end else if (hold_left == 0) begin
        hold_left = pick_gap(rx_gaps_on);
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare every level transfer with the oldest prediction.
  always @(posedge clk_i) begin : level_check
    envelope_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_envelopes.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected level transfer: level %0d pulse %0d segment %0d",
                   level_o, pulse_index_o, segment_o);
      end else begin
        want = pending_envelopes.pop_front();
        if (level_o !== want.level || pulse_index_o !== want.pulse ||
            segment_o !== want.seg) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch: level exp %0d got %0d, pulse exp %0d got %0d, %s",
                     want.level, level_o, want.pulse, pulse_index_o,
                     $sformatf("segment exp %0d got %0d", want.seg, segment_o));
        end
      end
    end
  end

  // Hang detector: count cycles with neither a tick nor a level transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: two rise ticks, a fall tick, then a restart.
  task automatic test_default_envelope();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Zero length and zero pulse count, then empty windows with an oversized,
  // masked pulse count; also poke the index that has no register.
  task automatic test_degenerate_timing();
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'd0);
    write_reg(CFG_PULSES_PER_BEAT, 16'd0);
    write_reg(CfgIdxUnused, 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'd3);
    write_reg(CFG_RISE_TICKS, 16'd0);
    write_reg(CFG_FALL_TICKS, 16'd0);
    // Upper bits are dropped: 5 bits give 17, which clamps to 16 pulses.
    write_reg(CFG_PULSES_PER_BEAT, 16'hFFF1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Full-scale base and accent saturate the peak; zero normal gain drives the
  // second pulse below base; windows longer than the pulse leave no gap.
  task automatic test_saturation_and_low_gain();
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'd4);
    write_reg(CFG_RISE_TICKS, 16'hFFFF);
    write_reg(CFG_FALL_TICKS, 16'hFFFF);
    write_reg(CFG_BASE_LEVEL, 16'hFFFF);
    write_reg(CFG_ACCENT_GAIN, 16'hFFFF);
    write_reg(CFG_NORMAL_GAIN, 16'd0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // Shrink the length and the pulse count below the running counters.
  task automatic test_counter_wrap_after_change();
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'hFFFF);
    write_reg(CFG_PULSES_PER_BEAT, 16'd16);
    write_reg(CFG_RISE_TICKS, 16'd2);
    write_reg(CFG_FALL_TICKS, 16'd3);
    write_reg(CFG_BASE_LEVEL, 16'd1000);
    write_reg(CFG_ACCENT_GAIN, 16'd3000);
    write_reg(CFG_NORMAL_GAIN, 16'd9000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'd2);
    send_tick(1'b0);
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'd1);
    repeat (3) send_tick(1'b0);
    settle();
    write_reg(CFG_PULSES_PER_BEAT, 16'd2);
    send_tick(1'b0);
  endtask

  // Stall the receiver for a long stretch while ticks keep coming, so the
  // output register fills and the input side backs up.
  task automatic test_output_backpressure();
    settle();
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    run_ticks(12, 0);
    tx_gaps_on   = 1'b1;
  endtask

  // Pick a fresh setting: mostly short pulses so beats wrap often, with the
  // degenerate and full-scale values mixed in.
  task automatic apply_random_settings();
    logic [DataW-1:0] len;
    int unsigned      window_max;
    int unsigned      roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)      len = 16'd0;
    else if (roll == 1) len = 16'hFFFF;
    else                len = 16'($urandom_range(1, 48));
    window_max = (len > 16'd48) ? 48 : len + 2;
    write_reg(CFG_PULSE_LENGTH, len);
    write_reg(CFG_RISE_TICKS, ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, window_max)));
    write_reg(CFG_FALL_TICKS, ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, window_max)));
    // Random upper bits exercise the masking of the 5-bit register.
    write_reg(CFG_PULSES_PER_BEAT, {11'($urandom), 5'($urandom_range(0, 31))});
    roll = $urandom_range(0, 9);
    if (roll == 0)      write_reg(CFG_BASE_LEVEL, 16'd0);
    else if (roll == 1) write_reg(CFG_BASE_LEVEL, 16'hFFFF);
    else                write_reg(CFG_BASE_LEVEL, 16'($urandom));
    write_reg(CFG_ACCENT_GAIN, ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(2048, 8192)));
    write_reg(CFG_NORMAL_GAIN, ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(2048, 8192)));
    if ($urandom_range(0, 3) == 0) write_reg(CfgIdxUnused, 16'($urandom));
  endtask

  // Random settings per phase; idling on each side switched per phase so some
  // phases run at full rate.
  task automatic test_random_envelopes();
    repeat (7) begin
      settle();
      apply_random_settings();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      run_ticks(245, 3);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_envelope_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_envelope();
    test_degenerate_timing();
    test_saturation_and_low_gain();
    test_counter_wrap_after_change();
    test_output_backpressure();
    test_random_envelopes();

    // Wait out the last levels; the hang detector bounds this.
    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
